@@ hw/rtl/msm_pkg.sv @@
// Shared types and codes for the multi-stack move and peek block.
// No dependencies; imported by the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package msm_pkg;

   localparam int PILE_W   = 5;
   localparam int POS_W    = 5;
   localparam int CARD_W   = 5;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 5;

   typedef logic [PILE_W-1:0]   pile_num_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [CARD_W-1:0]   card_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [CSR_W-1:0]    csr_type;

   localparam logic REQ_MOVE  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_EMPTY    = 2'd1;
   localparam status_type ST_POSITION = 2'd2;
   localparam status_type ST_RANGE    = 2'd3;

   localparam logic    CSR_PILES_IN_USE = 1'b0;
   localparam csr_type PILES_IN_USE_RST = 5'd16;

endpackage

`default_nettype wire

@@ hw/rtl/msm_req_if.sv @@
// Request channel: valid/ready handshake carrying one request beat.
// Depends on msm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface msm_req_if import msm_pkg::*; ();
   logic         valid;
   logic         ready;
   logic         req_type;
   pile_num_type source_pile;
   pile_num_type dest_pile;
   pos_type      position;

   modport source (output valid, req_type, source_pile, dest_pile, position, input ready);
   modport sink   (input valid, req_type, source_pile, dest_pile, position, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/msm_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result beat.
// Depends on msm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface msm_rsp_if import msm_pkg::*; ();
   logic       valid;
   logic       ready;
   card_type   card;
   status_type status;

   modport source (output valid, card, status, input ready);
   modport sink   (input valid, card, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/msm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module msm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/multi_stack_move_and_peek_top.sv @@
// Multi-stack move and peek: pile heights and pile slots in two RAMs.
// Depends on msm_pkg, msm_req_if, msm_rsp_if and msm_ram.
// One request at a time. A move reads the source height, then the top card and the
// destination height, writes the source height back, then pushes the card. A query
// reads the height, then the card; errors skip the remaining steps to the result beat.
// Reset (synchronous) starts an init pass that writes every pile's height and
// bottom card; no request is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module multi_stack_move_and_peek_top import msm_pkg::*; #(
   parameter int NUM_PILES = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   msm_req_if.sink    req_if,
   msm_rsp_if.source  rsp_if,
   input  wire logic  psel,
   input  wire logic  penable,
   input  wire logic  pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int PW  = $clog2(NUM_PILES);
   localparam int HW  = $clog2(NUM_PILES + 1);
   localparam int SD  = NUM_PILES * NUM_PILES;
   localparam int SAW = $clog2(SD);
   localparam int XW  = (PW > PILE_W) ? PW : PILE_W;

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HS     = 3'd2;
   localparam logic [2:0] S_QCARD  = 3'd3;
   localparam logic [2:0] S_MVCARD = 3'd4;
   localparam logic [2:0] S_MVPUSH = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   function automatic logic [PW-1:0] pile_idx(input pile_num_type p);
      logic [XW-1:0] t;
      t = XW'(p) - XW'(1);
      return t[PW-1:0];
   endfunction

   function automatic logic [SAW-1:0] slot_addr(input logic [31:0] p, input logic [31:0] k);
      return SAW'(p * 32'(NUM_PILES) + k);
   endfunction

   function automatic logic pile_ok(input pile_num_type p, input csr_type lim);
      return (p != '0) && (p <= lim) && (32'(p) <= 32'(NUM_PILES));
   endfunction

   logic [2:0]    state_ff, state_in;
   logic [PW-1:0] init_cnt_ff, init_cnt_in;
   csr_type       piles_in_use_ff, piles_in_use_in;
   logic          is_query_ff, is_query_in;
   logic [PW-1:0] src_ff, src_in;
   logic [PW-1:0] dst_ff, dst_in;
   pos_type       pos_ff, pos_in;
   logic [HW-1:0] hs_ff, hs_in;
   logic [HW-1:0] hd_ff, hd_in;
   logic [HW-1:0] card_ff, card_in;
   logic [HW-1:0] res_card_ff, res_card_in;
   status_type    res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   card_type      rsp_card_ff, rsp_card_in;
   status_type    rsp_status_ff, rsp_status_in;

   logic            h_we, h_re;
   logic [PW-1:0]   h_waddr, h_raddr;
   logic [HW-1:0]   h_wdata, h_rdata;
   logic            s_we, s_re;
   logic [SAW-1:0]  s_waddr, s_raddr;
   logic [HW-1:0]   s_wdata, s_rdata;

   logic req_beat, csr_wr, range_ok, rsp_free;
   logic [HW-1:0] hd_eff;

   msm_ram #(.WIDTH(HW), .DEPTH(NUM_PILES)) u_height_ram (
      .clock (clock),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (h_wdata),
      .re    (h_re),
      .raddr (h_raddr),
      .rdata (h_rdata)
   );

   msm_ram #(.WIDTH(HW), .DEPTH(SD)) u_slot_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .re    (s_re),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   assign req_if.ready  = (state_ff == S_IDLE);
   assign req_beat      = req_if.valid && req_if.ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.card   = rsp_card_ff;
   assign rsp_if.status = rsp_status_ff;
   assign rsp_free      = !rsp_valid_ff || rsp_if.ready;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == CSR_PILES_IN_USE) ? 32'(piles_in_use_ff) : 32'd0;

   assign range_ok = pile_ok(req_if.source_pile, piles_in_use_ff) &&
                     ((req_if.req_type == REQ_QUERY) ||
                      pile_ok(req_if.dest_pile, piles_in_use_ff));
   assign hd_eff   = (src_ff == dst_ff) ? HW'(hs_ff - 1'b1) : h_rdata;

   always_comb begin
      state_in        = state_ff;
      init_cnt_in     = init_cnt_ff;
      piles_in_use_in = piles_in_use_ff;
      is_query_in     = is_query_ff;
      src_in          = src_ff;
      dst_in          = dst_ff;
      pos_in          = pos_ff;
      hs_in           = hs_ff;
      hd_in           = hd_ff;
      card_in         = card_ff;
      res_card_in     = res_card_ff;
      res_status_in   = res_status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_card_in     = rsp_card_ff;
      rsp_status_in   = rsp_status_ff;
      h_we    = 1'b0;
      h_waddr = '0;
      h_wdata = '0;
      h_re    = 1'b0;
      h_raddr = '0;
      s_we    = 1'b0;
      s_waddr = '0;
      s_wdata = '0;
      s_re    = 1'b0;
      s_raddr = '0;

      if (csr_wr && (paddr[2] == CSR_PILES_IN_USE)) begin
         piles_in_use_in = pwdata[CSR_W-1:0];
      end

      case (state_ff)
         S_INIT: begin
            h_we    = 1'b1;
            h_waddr = init_cnt_ff;
            h_wdata = HW'(1);
            s_we    = 1'b1;
            s_waddr = slot_addr(32'(init_cnt_ff), 32'd0);
            s_wdata = HW'(32'(init_cnt_ff) + 32'd1);
            init_cnt_in = PW'(32'(init_cnt_ff) + 32'd1);
            if (init_cnt_ff == PW'(NUM_PILES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_beat) begin
               is_query_in = (req_if.req_type == REQ_QUERY);
               src_in      = pile_idx(req_if.source_pile);
               dst_in      = pile_idx(req_if.dest_pile);
               pos_in      = req_if.position;
               if (range_ok) begin
                  h_re     = 1'b1;
                  h_raddr  = pile_idx(req_if.source_pile);
                  state_in = S_HS;
               end else begin
                  res_card_in   = '0;
                  res_status_in = ST_RANGE;
                  state_in      = S_EMIT;
               end
            end
         end
         S_HS: begin
            hs_in = h_rdata;
            if (is_query_ff) begin
               if ((pos_ff == '0) || (32'(pos_ff) > 32'(h_rdata)) ||
                   (32'(pos_ff) > 32'(NUM_PILES))) begin
                  res_card_in   = '0;
                  res_status_in = ST_POSITION;
                  state_in      = S_EMIT;
               end else begin
                  s_re     = 1'b1;
                  s_raddr  = slot_addr(32'(src_ff), 32'(pos_ff) - 32'd1);
                  state_in = S_QCARD;
               end
            end else if (h_rdata == '0) begin
               res_card_in   = '0;
               res_status_in = ST_EMPTY;
               state_in      = S_EMIT;
            end else begin
               s_re     = 1'b1;
               s_raddr  = slot_addr(32'(src_ff), 32'(h_rdata) - 32'd1);
               h_re     = 1'b1;
               h_raddr  = dst_ff;
               state_in = S_MVCARD;
            end
         end
         S_QCARD: begin
            res_card_in   = s_rdata;
            res_status_in = ST_OK;
            state_in      = S_EMIT;
         end
         S_MVCARD: begin
            card_in  = s_rdata;
            hd_in    = hd_eff;
            h_we     = 1'b1;
            h_waddr  = src_ff;
            h_wdata  = HW'(hs_ff - 1'b1);
            state_in = S_MVPUSH;
         end
         S_MVPUSH: begin
            h_we     = 1'b1;
            h_waddr  = dst_ff;
            h_wdata  = HW'(32'(hd_ff) + 32'd1);
            s_we     = 1'b1;
            s_waddr  = slot_addr(32'(dst_ff), 32'(hd_ff));
            s_wdata  = card_ff;
            res_card_in   = card_ff;
            res_status_in = ST_OK;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_card_in   = CARD_W'(res_card_ff);
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_INIT;
         init_cnt_ff     <= '0;
         piles_in_use_ff <= PILES_IN_USE_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         init_cnt_ff     <= init_cnt_in;
         piles_in_use_ff <= piles_in_use_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_query_ff   <= is_query_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      pos_ff        <= pos_in;
      hs_ff         <= hs_in;
      hd_ff         <= hd_in;
      card_ff       <= card_in;
      res_card_ff   <= res_card_in;
      res_status_ff <= res_status_in;
      rsp_card_ff   <= rsp_card_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_err_card_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> (rsp_card_ff == '0))
      else $error("non-ok result carries a card");

   a_init_blocks_req: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_if.ready && (init_cnt_ff == '0))
      else $error("request taken before init pass");

   a_push_after_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MVPUSH) |-> ($past(state_ff) == S_MVCARD))
      else $error("push without pop");

   a_emit_holds_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) && rsp_valid_ff && !rsp_if.ready |=> (state_ff == S_EMIT))
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire
